FILE: rtl/core/qte_pkg.sv
// Package for the quaternion to Euler angle converter.
// Holds widths, angle constants, pipeline types and the CORDIC angle table.
// No dependencies.
`default_nettype none

package qte_pkg;

    localparam int AW           = 38;
    localparam int NW           = 41;
    localparam int CW           = 45;
    localparam int ZW           = 29;
    localparam int PW           = 34;
    localparam int TW           = 31;
    localparam int THR_W        = 30;
    localparam int SQW          = 62;
    localparam int SQ_STEPS     = 31;
    localparam int NORM_STEPS   = 6;
    localparam int CORDIC_STEPS = 27;
    localparam int ATAN_LAT     = NORM_STEPS + CORDIC_STEPS + 2;

    localparam logic signed [ZW-1:0] DEG90     = 29'sd94371840;
    localparam logic signed [ZW-1:0] DEG180    = 29'sd188743680;
    localparam logic signed [TW-1:0] DEG180_T  = 31'sd188743680;
    localparam logic signed [TW-1:0] DEG360_T  = 31'sd377487360;
    localparam logic signed [27:0]   PITCH_POS = 28'sd94371840;
    localparam logic signed [27:0]   PITCH_NEG = -28'sd94371840;
    localparam logic signed [AW-1:0] Q30_ONE_A = 38'sd1073741824;
    localparam logic [THR_W-1:0]     THR_RESET = 30'd536870375;
    localparam logic                 REG_THR_SEL = 1'b0;

    typedef enum logic [1:0] {
        POLE_REGULAR = 2'd0,
        POLE_LOW     = 2'd1,
        POLE_HIGH    = 2'd2
    } t_pole;

    typedef struct packed {
        logic  valid;
        t_pole pole;
    } t_ctl;

    typedef struct packed {
        logic signed [AW-1:0] yaw_y;
        logic signed [AW-1:0] yaw_x;
        logic signed [AW-1:0] b_y;
        logic signed [AW-1:0] b_x;
        logic signed [31:0]   v;
    } t_side;

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic xzero;
        logic yzero;
    } t_atan_fl;

    function automatic logic signed [PW-1:0] mulq(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[63:30];
    endfunction

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = 29'sd47185920;
            1:       v = 29'sd27855475;
            2:       v = 29'sd14718068;
            3:       v = 29'sd7471121;
            4:       v = 29'sd3750058;
            5:       v = 29'sd1876857;
            6:       v = 29'sd938658;
            7:       v = 29'sd469357;
            8:       v = 29'sd234682;
            9:       v = 29'sd117342;
            10:      v = 29'sd58671;
            11:      v = 29'sd29335;
            12:      v = 29'sd14668;
            13:      v = 29'sd7334;
            14:      v = 29'sd3667;
            15:      v = 29'sd1833;
            16:      v = 29'sd917;
            17:      v = 29'sd458;
            18:      v = 29'sd229;
            19:      v = 29'sd115;
            20:      v = 29'sd57;
            21:      v = 29'sd29;
            22:      v = 29'sd14;
            23:      v = 29'sd7;
            24:      v = 29'sd4;
            25:      v = 29'sd2;
            26:      v = 29'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qte_quat_if.sv
// Input channel carrying one quaternion per transfer.
// Depends on nothing.
`default_nettype none

interface qte_quat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink (input valid, input quat_x, input quat_y, input quat_z,
                  input quat_w, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/qte_euler_if.sv
// Output channel carrying pitch, yaw, roll and the pole case per transfer.
// Depends on nothing.
`default_nettype none

interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [27:0] pitch_deg;
    logic signed [28:0] yaw_deg;
    logic signed [28:0] roll_deg;
    logic [1:0]         pole_case;

    modport source (output valid, output pitch_deg, output yaw_deg, output roll_deg,
                    output pole_case, input ready);
    modport sink (input valid, input pitch_deg, input yaw_deg, input roll_deg,
                  input pole_case, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/qte_atan2.sv
// Pipelined atan2 in degrees: magnitude, normalization and CORDIC vectoring.
// Depends on qte_pkg.
`default_nettype none

module qte_atan2 import qte_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_y,
    input  logic signed [AW-1:0] i_x,
    output logic signed [ZW-1:0] o_ang
);

    localparam int LAST_FL = NORM_STEPS + CORDIC_STEPS;

    logic [NW-1:0]        r_nx  [0:NORM_STEPS];
    logic [NW-1:0]        r_ny  [0:NORM_STEPS];
    t_atan_fl             r_fl  [0:LAST_FL];
    logic signed [CW-1:0] r_cx  [0:CORDIC_STEPS-1];
    logic signed [CW-1:0] r_cy  [0:CORDIC_STEPS-1];
    logic signed [ZW-1:0] r_z   [0:CORDIC_STEPS-1];
    logic signed [ZW-1:0] r_ang;
    logic signed [ZW-1:0] n_ang;
    logic signed [ZW-1:0] w_a;
    logic [AW-1:0]        w_ax;
    logic [AW-1:0]        w_ay;

    assign w_ax = i_x[AW-1] ? AW'(-i_x) : AW'(i_x);
    assign w_ay = i_y[AW-1] ? AW'(-i_y) : AW'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0] <= NW'(w_ax);
            r_ny[0] <= NW'(w_ay);
            r_fl[0] <= '{xneg: i_x[AW-1], yneg: i_y[AW-1],
                         xzero: (i_x == '0), yzero: (i_y == '0)};
        end
    end

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic [NW-1:0] w_m;
        logic          w_do;
        assign w_m  = r_nx[j] | r_ny[j];
        assign w_do = (w_m[NW-1 -: SH] == '0);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nx[j+1] <= w_do ? (r_nx[j] << SH) : r_nx[j];
                r_ny[j+1] <= w_do ? (r_ny[j] << SH) : r_ny[j];
                r_fl[j+1] <= r_fl[j];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [CW-1:0] w_cx;
        logic signed [CW-1:0] w_cy;
        logic signed [ZW-1:0] w_z;
        logic signed [CW-1:0] w_dx;
        logic signed [CW-1:0] w_dy;
        if (i == 0) begin : g_first
            assign w_cx = CW'($signed({1'b0, r_nx[NORM_STEPS]}));
            assign w_cy = CW'($signed({1'b0, r_ny[NORM_STEPS]}));
            assign w_z  = '0;
        end else begin : g_next
            assign w_cx = r_cx[i-1];
            assign w_cy = r_cy[i-1];
            assign w_z  = r_z[i-1];
        end
        assign w_dx = w_cy >>> i;
        assign w_dy = w_cx >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_cy > 0) begin
                    r_cx[i] <= w_cx + w_dx;
                    r_cy[i] <= w_cy - w_dy;
                    r_z[i]  <= w_z + atan_tab(i);
                end else begin
                    r_cx[i] <= w_cx - w_dx;
                    r_cy[i] <= w_cy + w_dy;
                    r_z[i]  <= w_z - atan_tab(i);
                end
                r_fl[NORM_STEPS+1+i] <= r_fl[NORM_STEPS+i];
            end
        end
    end

    always_comb begin
        if (r_fl[LAST_FL].yzero) begin
            w_a = '0;
        end else if (r_fl[LAST_FL].xzero) begin
            w_a = DEG90;
        end else if (r_z[CORDIC_STEPS-1] < 0) begin
            w_a = '0;
        end else if (r_z[CORDIC_STEPS-1] > DEG90) begin
            w_a = DEG90;
        end else begin
            w_a = r_z[CORDIC_STEPS-1];
        end
        if (!r_fl[LAST_FL].xneg) begin
            n_ang = r_fl[LAST_FL].yneg ? -w_a : w_a;
        end else begin
            n_ang = r_fl[LAST_FL].yneg ? (w_a - DEG180) : (DEG180 - w_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
        end
    end

    assign o_ang = r_ang;

endmodule

`default_nettype wire

FILE: rtl/core/quaternion_to_euler_degrees_top.sv
// Channel      Dir  Payload
// i_quat       in   quat_x, quat_y, quat_z, quat_w (signed Q2.30)
// o_euler      out  pitch_deg, yaw_deg, roll_deg (signed Q.20 degrees), pole_case
// APB          in   pole threshold register at byte address 0
//
// One quaternion is taken per cycle unless the pipeline is held for a full output.
// Each result passes through the 31-step square root and the 35-stage atan2 units in series.
// The whole pipeline advances together and holds while the output is full and not taken.
// Reset is synchronous and active low; it clears valid bits and reloads the threshold.
// Depends on qte_pkg, qte_quat_if, qte_euler_if and qte_atan2.
`default_nettype none

module quaternion_to_euler_degrees_top import qte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SIDE_N  = 2 + SQ_STEPS;
    localparam int CTL_P1  = SIDE_N + ATAN_LAT;
    localparam int CTL_N   = CTL_P1 + 2;

    logic en;

    logic [THR_W-1:0] r_thr;

    logic                 r1_valid;
    logic signed [PW-1:0] r1_zx, r1_wy, r1_wz, r1_xy, r1_yy, r1_zz, r1_wx, r1_yz, r1_xx;
    logic signed [31:0]   r1_x, r1_w;

    logic signed [34:0]   c_s;
    logic signed [34:0]   c_thr;
    logic signed [35:0]   c_2s;
    t_pole                c_pole;
    t_side                c_side;
    t_ctl                 r2_ctl;
    t_side                r2_side;

    t_ctl                 r_ctl  [0:CTL_N-1];
    t_side                r_side [0:SIDE_N-1];
    logic [60:0]          r3_vv;
    logic [60:0]          r4_n;
    logic signed [63:0]   c_vv;
    logic [SQW-1:0]       r_sq_n [0:SQ_STEPS-1];
    logic [SQW-1:0]       r_sq_r [0:SQ_STEPS-1];

    logic signed [AW-1:0] c_pitch_x;
    logic signed [ZW-1:0] w_yaw, w_b, w_pitch;

    logic signed [ZW-1:0] r_p1_yaw, r_p1_b, r_p1_pitch;
    logic signed [TW-1:0] r_p1_t;
    logic signed [ZW-1:0] r_p2_yaw, r_p2_b, r_p2_pitch;
    logic signed [TW-1:0] r_p2_m;
    logic signed [TW-1:0] n_p1_t, n_p2_m, c_wrap;

    logic               r_out_valid;
    logic signed [27:0] r_out_pitch, n_out_pitch;
    logic signed [28:0] r_out_yaw;
    logic signed [28:0] r_out_roll, n_out_roll;
    t_pole              r_out_pole;

    assign en           = !r_out_valid || o_euler.ready;
    assign i_quat.ready = en;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THR_SEL) ? {2'b00, r_thr} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_THR_SEL) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    // Stage 1: component products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_quat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_zx <= mulq(i_quat.quat_z, i_quat.quat_x);
            r1_wy <= mulq(i_quat.quat_w, i_quat.quat_y);
            r1_wz <= mulq(i_quat.quat_w, i_quat.quat_z);
            r1_xy <= mulq(i_quat.quat_x, i_quat.quat_y);
            r1_yy <= mulq(i_quat.quat_y, i_quat.quat_y);
            r1_zz <= mulq(i_quat.quat_z, i_quat.quat_z);
            r1_wx <= mulq(i_quat.quat_w, i_quat.quat_x);
            r1_yz <= mulq(i_quat.quat_y, i_quat.quat_z);
            r1_xx <= mulq(i_quat.quat_x, i_quat.quat_x);
            r1_x  <= i_quat.quat_x;
            r1_w  <= i_quat.quat_w;
        end
    end

    // Stage 2: sums, pole decision and the clamped asin argument.
    assign c_s   = 35'(r1_zx) - 35'(r1_wy);
    assign c_thr = $signed({5'b00000, r_thr});
    assign c_2s  = 36'(c_s) <<< 1;

    always_comb begin
        if (c_s < -c_thr) begin
            c_pole = POLE_LOW;
        end else if (c_s > c_thr) begin
            c_pole = POLE_HIGH;
        end else begin
            c_pole = POLE_REGULAR;
        end
        c_side.yaw_y = (AW'(r1_wz) + AW'(r1_xy)) <<< 1;
        c_side.yaw_x = Q30_ONE_A - ((AW'(r1_yy) + AW'(r1_zz)) <<< 1);
        if (c_pole == POLE_REGULAR) begin
            c_side.b_y = -((AW'(r1_wx) + AW'(r1_yz)) <<< 1);
            c_side.b_x = Q30_ONE_A - ((AW'(r1_xx) + AW'(r1_yy)) <<< 1);
        end else begin
            c_side.b_y = AW'(r1_x);
            c_side.b_x = AW'(r1_w);
        end
        if (c_2s > 36'sd1073741824) begin
            c_side.v = 32'sd1073741824;
        end else if (c_2s < -36'sd1073741824) begin
            c_side.v = -32'sd1073741824;
        end else begin
            c_side.v = 32'(c_2s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (en) begin
            r2_ctl <= '{valid: r1_valid, pole: c_pole};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side <= c_side;
        end
    end

    // Control and side-band delay lines.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CTL_N; i++) begin
                r_ctl[i] <= '0;
            end
        end else if (en) begin
            r_ctl[0] <= r2_ctl;
            for (int i = 1; i < CTL_N; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r2_side;
            for (int i = 1; i < SIDE_N; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Stages 3 and 4: radicand 1 - v*v.
    assign c_vv = r2_side.v * r2_side.v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_vv <= c_vv[60:0];
            r4_n  <= (61'd1 << 60) - r3_vv;
        end
    end

    // Square root, one result bit per stage.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQW-1:0] BIT = SQW'(1) << (60 - 2 * k);
        logic [SQW-1:0] w_n;
        logic [SQW-1:0] w_r;
        logic [SQW-1:0] w_sum;
        if (k == 0) begin : g_first
            assign w_n = SQW'(r4_n);
            assign w_r = '0;
        end else begin : g_next
            assign w_n = r_sq_n[k-1];
            assign w_r = r_sq_r[k-1];
        end
        assign w_sum = w_r + BIT;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (w_n >= w_sum) begin
                    r_sq_n[k] <= w_n - w_sum;
                    r_sq_r[k] <= (w_r >> 1) + BIT;
                end else begin
                    r_sq_n[k] <= w_n;
                    r_sq_r[k] <= w_r >> 1;
                end
            end
        end
    end

    assign c_pitch_x = $signed(AW'(r_sq_r[SQ_STEPS-1]));

    qte_atan2 u_atan_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_side[SIDE_N-1].yaw_y),
        .i_x   (r_side[SIDE_N-1].yaw_x),
        .o_ang (w_yaw)
    );

    qte_atan2 u_atan_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_side[SIDE_N-1].b_y),
        .i_x   (r_side[SIDE_N-1].b_x),
        .o_ang (w_b)
    );

    qte_atan2 u_atan_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (AW'(r_side[SIDE_N-1].v)),
        .i_x   (c_pitch_x),
        .o_ang (w_pitch)
    );

    // Pole roll: combine, then reduce into the half-open turn.
    assign n_p1_t = ((r_ctl[CTL_P1-1].pole == POLE_LOW) ? -TW'(w_yaw) : TW'(w_yaw))
                    - (TW'(w_b) <<< 1);

    always_comb begin
        if (r_p1_t < -DEG360_T) begin
            n_p2_m = r_p1_t + (DEG360_T <<< 1);
        end else if (r_p1_t < 0) begin
            n_p2_m = r_p1_t + DEG360_T;
        end else if (r_p1_t >= DEG360_T) begin
            n_p2_m = r_p1_t - DEG360_T;
        end else begin
            n_p2_m = r_p1_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_yaw   <= w_yaw;
            r_p1_b     <= w_b;
            r_p1_pitch <= w_pitch;
            r_p1_t     <= n_p1_t;
            r_p2_yaw   <= r_p1_yaw;
            r_p2_b     <= r_p1_b;
            r_p2_pitch <= r_p1_pitch;
            r_p2_m     <= n_p2_m;
        end
    end

    // Output register.
    assign c_wrap = (r_p2_m > DEG180_T) ? (r_p2_m - DEG360_T) : r_p2_m;

    always_comb begin
        case (r_ctl[CTL_N-1].pole)
            POLE_LOW: begin
                n_out_pitch = PITCH_NEG;
                n_out_roll  = 29'(c_wrap);
            end
            POLE_HIGH: begin
                n_out_pitch = PITCH_POS;
                n_out_roll  = 29'(c_wrap);
            end
            default: begin
                n_out_pitch = 28'(r_p2_pitch);
                n_out_roll  = r_p2_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_ctl[CTL_N-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pitch <= n_out_pitch;
            r_out_yaw   <= r_p2_yaw;
            r_out_roll  <= n_out_roll;
            r_out_pole  <= r_ctl[CTL_N-1].pole;
        end
    end

    assign o_euler.valid     = r_out_valid;
    assign o_euler.pitch_deg = r_out_pitch;
    assign o_euler.yaw_deg   = r_out_yaw;
    assign o_euler.roll_deg  = r_out_roll;
    assign o_euler.pole_case = r_out_pole;

    a_pole_high_pitch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid && o_euler.pole_case == POLE_HIGH |-> o_euler.pitch_deg == PITCH_POS)
        else $error("pitch not pinned high at the upper pole");

    a_pole_low_pitch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid && o_euler.pole_case == POLE_LOW |-> o_euler.pitch_deg == PITCH_NEG)
        else $error("pitch not pinned low at the lower pole");

    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_quat.ready |-> o_euler.valid && !o_euler.ready)
        else $error("input held off without a pending output");

    a_yaw_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> o_euler.yaw_deg <= 29'(DEG180) && o_euler.yaw_deg >= -29'(DEG180))
        else $error("yaw outside one half turn");

endmodule

`default_nettype wire

FILE: verif/qte_checker.sv
// Checker for the quaternion to Euler angle converter: watches both channels,
// predicts each result from the accepted quaternion and compares field by field.
// Depends on qte_pkg, qte_quat_if and qte_euler_if.
module qte_checker import qte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qte_quat_if         quat,
    qte_euler_if        euler,
    input  logic [29:0] i_threshold,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [27:0] pitch;
        logic signed [28:0] yaw;
        logic signed [28:0] roll;
        t_pole              pole;
    } t_euler;

    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint NINETY    = 64'sd94371840;
    localparam longint HALF_TURN = 64'sd188743680;
    localparam longint FULL_TURN = 64'sd377487360;

    t_euler angles_due[$];
    longint angle_steps[27] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14, 7, 4, 2, 1};

    function automatic longint prod_q30(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 30;
    endfunction

    function automatic longint root_floor(longint n);
        longint lo, hi, mid;
        lo = 0;
        hi = 64'd2147483648;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint angle_of(longint y, longint x);
        longint ax, ay, cx, cy, dx, dy, z, a;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        z = 0;
        if (ay == 0) a = 0;
        else if (ax == 0) a = NINETY;
        else begin
            while (ax < 64'sd1099511627776 && ay < 64'sd1099511627776) begin
                ax = ax <<< 1;
                ay = ay <<< 1;
            end
            cx = ax;
            cy = ay;
            for (int i = 0; i < 27; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy > 0) begin
                    cx += dx; cy -= dy; z += angle_steps[i];
                end else begin
                    cx -= dx; cy += dy; z -= angle_steps[i];
                end
            end
            a = z < 0 ? 0 : (z > NINETY ? NINETY : z);
        end
        if (x >= 0) return y < 0 ? -a : a;
        return y < 0 ? a - HALF_TURN : HALF_TURN - a;
    endfunction

    function automatic longint wrap_half(longint a);
        longint r;
        r = a % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        if (r > HALF_TURN) r -= FULL_TURN;
        return r;
    endfunction

    function automatic t_euler euler_of(longint x, longint y, longint z, longint w,
                                        longint thr);
        t_euler e;
        longint s, yaw, v, r, pitch, roll;
        s = prod_q30(z, x) - prod_q30(w, y);
        yaw = angle_of(2 * (prod_q30(w, z) + prod_q30(x, y)),
                       ONE_Q30 - 2 * (prod_q30(y, y) + prod_q30(z, z)));
        if (s < -thr) begin
            e.pole = POLE_LOW;
            pitch = -NINETY;
            roll = wrap_half(-yaw - 2 * angle_of(x, w));
        end else if (s > thr) begin
            e.pole = POLE_HIGH;
            pitch = NINETY;
            roll = wrap_half(yaw - 2 * angle_of(x, w));
        end else begin
            e.pole = POLE_REGULAR;
            v = 2 * s;
            if (v > ONE_Q30) v = ONE_Q30;
            if (v < -ONE_Q30) v = -ONE_Q30;
            r = root_floor((64'sd1 <<< 60) - v * v);
            pitch = angle_of(v, r);
            roll = angle_of(-2 * (prod_q30(w, x) + prod_q30(y, z)),
                            ONE_Q30 - 2 * (prod_q30(x, x) + prod_q30(y, y)));
        end
        e.pitch = pitch[27:0];
        e.yaw = yaw[28:0];
        e.roll = roll[28:0];
        return e;
    endfunction

    assign o_pending = angles_due.size();

    always @(posedge i_clk) begin
        t_euler e;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (quat.valid && quat.ready)
                angles_due.push_back(euler_of(quat.quat_x, quat.quat_y, quat.quat_z,
                                              quat.quat_w, longint'(i_threshold)));
            if (euler.valid && euler.ready) begin
                if (angles_due.size() == 0) begin
                    $display("%0t: unexpected result transfer", $time);
                    o_errors <= o_errors + 1;
                end else begin
                    e = angles_due.pop_front();
                    if (e.pitch !== euler.pitch_deg || e.yaw !== euler.yaw_deg ||
                        e.roll !== euler.roll_deg || e.pole !== euler.pole_case) begin
                        $display("%0t: expected p=%0d y=%0d r=%0d c=%0d got p=%0d y=%0d r=%0d c=%0d",
                                 $time, e.pitch, e.yaw, e.roll, e.pole, euler.pitch_deg,
                                 euler.yaw_deg, euler.roll_deg, euler.pole_case);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/testbench.sv
// Top of the converter testbench: drives quaternions, stalls the output and
// writes the threshold over APB; the verdict comes from qte_checker's count.
// Depends on qte_pkg, qte_quat_if, qte_euler_if, qte_checker and the top level.
module testbench;
    import qte_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic [29:0] threshold = THR_RESET;
    logic        stall_free = 1'b0;
    int          ready_hold = 0;
    int          errors, pending;

    qte_quat_if  quat ();
    qte_euler_if euler ();

    quaternion_to_euler_degrees_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_quat(quat), .o_euler(euler),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    qte_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .quat(quat), .euler(euler),
        .i_threshold(threshold), .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        quat.valid = 1'b0;
        quat.quat_x = '0;
        quat.quat_y = '0;
        quat.quat_z = '0;
        quat.quat_w = '0;
        euler.ready = 1'b0;
    end

    function automatic int pause_length();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    always @(posedge i_clk) begin
        if (stall_free) begin
            euler.ready <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            euler.ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 3) != 0) begin
            euler.ready <= 1'b1;
        end else begin
            euler.ready <= 1'b0;
            ready_hold <= pause_length();
        end
    end

    task automatic send_quat(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] w, int gap);
        repeat (gap) begin
            quat.valid <= 1'b0;
            @(posedge i_clk);
        end
        quat.valid <= 1'b1;
        quat.quat_x <= x;
        quat.quat_y <= y;
        quat.quat_z <= z;
        quat.quat_w <= w;
        @(posedge i_clk);
        while (!quat.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        quat.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [29:0] value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_THRESHOLD; pwdata <= {2'b00, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        threshold <= value;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_component(int shape);
        case (shape)
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 2147483647)) >>> 1) *
                      ($urandom_range(0, 1) ? 1 : -1);
            default: return 32'($signed($urandom_range(0, 1073741824))) *
                            ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    task automatic random_items(int count);
        int shape;
        logic [31:0] q;
        for (int n = 0; n < count; n++) begin
            shape = $urandom_range(0, 9);
            if (shape < 3) begin
                // near the poles: x and z alike, y and w opposite
                q = pick_component(3);
                send_quat(q, -q + $urandom_range(0, 4000) - 2000,
                          q + $urandom_range(0, 4000) - 2000, q, pause_length());
            end else if (shape < 5) begin
                send_quat(pick_component(0), pick_component(0), pick_component(0),
                          pick_component(0), pause_length());
            end else if (shape == 5) begin
                send_quat(pick_component(1), pick_component(2), pick_component(3),
                          pick_component(1), pause_length());
            end else begin
                send_quat(pick_component(3) >>> $urandom_range(0, 1), pick_component(3) >>>
                          $urandom_range(0, 1), pick_component(3) >>> $urandom_range(0, 1),
                          pick_component(3) >>> $urandom_range(0, 1),
                          $urandom_range(0, 5) == 0 ? 0 : pause_length());
            end
        end
    endtask

    initial begin
        logic [31:0] h;
        h = 32'sh2000_0000;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_threshold(THR_RESET);
        send_quat(0, 0, 0, 0, 0);
        send_quat(0, 0, 0, 32'h4000_0000, 0);
        send_quat(32'h4000_0000, 0, 0, 0, 0);
        send_quat(0, 32'h4000_0000, 0, 0, 0);
        send_quat(0, 0, 32'h4000_0000, 0, 0);
        send_quat(0, 0, 0, 32'hc000_0000, 0);
        send_quat(32'hc000_0000, 0, 0, 0, 0);
        send_quat(h, -h, h, h, 0);
        send_quat(h, h, h, h, 0);
        send_quat(h, h, -h, -h, 1);
        send_quat(-h, h, h, -h, 0);
        send_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_quat(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_quat(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_quat(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 2);
        send_quat(0, 32'hc000_0000, 0, 32'hc000_0000, 0);
        send_quat(0, 32'hc000_0000, 0, 32'h4000_0000, 0);
        random_items(400);
        stall_free = 1'b1;
        drain();
        stall_free = 1'b0;
        write_threshold(30'd0);
        send_quat(0, 0, 0, 32'h4000_0000, 0);
        send_quat(32'h0000_8000, 0, 32'h0000_8000, 0, 0);
        random_items(350);
        drain();
        write_threshold(30'h3fff_ffff);
        random_items(350);
        drain();
        write_threshold(30'd268435456);
        random_items(350);
        drain();
        write_threshold(THR_RESET);
        random_items(350);
        drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("FAIL");
        $finish;
    end
endmodule
